[hdl/sse_data_event_parser_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the event parser modules.
// ----------------------------------------------------------------------------
`ifndef SSE_DATA_EVENT_PARSER_MACROS_SVH
`define SSE_DATA_EVENT_PARSER_MACROS_SVH

// The condition holds in the same cycle as the trigger.
`define SDEP_ASSERT_SAME(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// The condition holds in the cycle after the trigger.
`define SDEP_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

[hdl/sdep_pkg.sv]
// ----------------------------------------------------------------------------
// sdep_pkg
// Shared types and constants of the event stream data parser.
// ----------------------------------------------------------------------------
`default_nettype none

package sdep_pkg;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_PREFIX = 3'd1,
        PH_COLON  = 3'd2,
        PH_VALUE  = 3'd3,
        PH_SKIP   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_DONE = 2'd2
    } t_kind;

    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_SPACE = 8'h20;

    localparam logic [2:0] DATA_TAG_LEN = 3'd5;
    localparam logic [2:0] DONE_TAG_LEN = 3'd6;

    // One command per input byte: held done-tag bytes to replay, up to two
    // literal data bytes, then an optional event marker.
    typedef struct packed {
        logic [2:0] flush_n;
        logic       b0_v;
        logic [7:0] b0;
        logic       b1_v;
        logic [7:0] b1;
        logic       mark_v;
        t_kind      mark;
    } t_cmd;

    function automatic logic [7:0] done_tag(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h5B; // [
            3'd1:    c = 8'h44; // D
            3'd2:    c = 8'h4F; // O
            3'd3:    c = 8'h4E; // N
            3'd4:    c = 8'h45; // E
            3'd5:    c = 8'h5D; // ]
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[hdl/sdep_front.sv]
// ----------------------------------------------------------------------------
// sdep_front
// Accepts raw bytes, tracks line and event state and turns each byte into a
// compact output command.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sse_data_event_parser_macros.svh"

module sdep_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic [7:0]    i_rx_byte,
    input  wire logic          i_q_full,
    output logic               o_in_stall,
    output logic               o_push,
    output sdep_pkg::t_cmd     o_cmd
);
    import sdep_pkg::*;

    typedef struct packed {
        t_phase     phase;
        logic [2:0] prefix_pos;
        logic       cr_held;
        logic       have_data;
        logic [2:0] done_count;
        logic       done_broken;
    } t_state;

    typedef struct packed {
        t_state st;
        t_cmd   cmd;
    } t_work;

    function automatic logic [7:0] data_tag(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h64; // d
            3'd1:    c = 8'h61; // a
            3'd2:    c = 8'h74; // t
            3'd3:    c = 8'h61; // a
            3'd4:    c = 8'h3A; // :
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic t_work f_append(input t_work w_in, input logic [7:0] b);
        t_work w;
        w = w_in;
        if (!w.cmd.b0_v) begin
            w.cmd.b0_v = 1'b1;
            w.cmd.b0   = b;
        end else begin
            w.cmd.b1_v = 1'b1;
            w.cmd.b1   = b;
        end
        return w;
    endfunction

    function automatic t_work f_value(input t_work w_in, input logic [7:0] b);
        t_work w;
        w = w_in;
        if (w.st.done_broken) begin
            w = f_append(w, b);
        end else if (w.st.done_count < DONE_TAG_LEN && b == done_tag(w.st.done_count)) begin
            w.st.done_count = w.st.done_count + 3'd1;
        end else begin
            w.st.done_broken = 1'b1;
            w.cmd.flush_n    = w.st.done_count;
            w.st.done_count  = 3'd0;
            w = f_append(w, b);
        end
        return w;
    endfunction

    function automatic t_work f_line(input t_work w_in, input logic [7:0] b);
        t_work w;
        w = w_in;
        unique case (w.st.phase)
            PH_START: begin
                if (b == data_tag(3'd0)) begin
                    w.st.phase      = PH_PREFIX;
                    w.st.prefix_pos = 3'd1;
                end else begin
                    w.st.phase = PH_SKIP;
                end
            end
            PH_PREFIX: begin
                if (w.st.prefix_pos < DATA_TAG_LEN && b == data_tag(w.st.prefix_pos)) begin
                    w.st.prefix_pos = w.st.prefix_pos + 3'd1;
                    if (w.st.prefix_pos == DATA_TAG_LEN) begin
                        // A further data line in the same event is joined by LF.
                        if (w.st.have_data) begin
                            w = f_value(w, CHR_LF);
                        end
                        w.st.have_data = 1'b1;
                        w.st.phase     = PH_COLON;
                    end
                end else begin
                    w.st.phase = PH_SKIP;
                end
            end
            PH_COLON: begin
                w.st.phase = PH_VALUE;
                if (b != CHR_SPACE) begin
                    w = f_value(w, b);
                end
            end
            PH_VALUE: begin
                w = f_value(w, b);
            end
            default: begin
                w.st.phase = PH_SKIP;
            end
        endcase
        return w;
    endfunction

    function automatic t_work f_line_end(input t_work w_in);
        t_work w;
        w = w_in;
        if (w.st.phase == PH_START && w.st.have_data) begin
            w.cmd.mark_v = 1'b1;
            if (!w.st.done_broken && w.st.done_count == DONE_TAG_LEN) begin
                w.cmd.mark = KIND_DONE;
            end else begin
                if (!w.st.done_broken) begin
                    w.cmd.flush_n = w.st.done_count;
                end
                w.cmd.mark = KIND_END;
            end
            w.st.have_data   = 1'b0;
            w.st.done_count  = 3'd0;
            w.st.done_broken = 1'b0;
        end
        w.st.phase      = PH_START;
        w.st.prefix_pos = 3'd0;
        return w;
    endfunction

    t_state r_st;
    t_state n_st;
    t_work  w_step;
    logic   accept;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        w_step.st  = r_st;
        w_step.cmd = '0;
        if (i_rx_byte == CHR_LF) begin
            w_step.st.cr_held = 1'b0;
            w_step = f_line_end(w_step);
        end else if (i_rx_byte == CHR_CR) begin
            // A CR after a held CR releases the older one as a line byte.
            if (r_st.cr_held) begin
                w_step = f_line(w_step, CHR_CR);
            end
            w_step.st.cr_held = 1'b1;
        end else begin
            if (r_st.cr_held) begin
                w_step.st.cr_held = 1'b0;
                w_step = f_line(w_step, CHR_CR);
            end
            w_step = f_line(w_step, i_rx_byte);
        end
        n_st   = w_step.st;
        o_cmd  = w_step.cmd;
        o_push = accept && (w_step.cmd.flush_n != 3'd0 || w_step.cmd.b0_v
                            || w_step.cmd.mark_v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // All fields clear; the line start phase is encoded as zero.
            r_st <= '0;
        end else if (accept) begin
            r_st <= n_st;
        end
    end

    `SDEP_ASSERT_NEXT(a_lf_resets_line, i_clk, i_rst_n, accept && i_rx_byte == CHR_LF,
        !r_st.cr_held && r_st.phase == PH_START && r_st.prefix_pos == 3'd0,
        "line state not cleared after LF")
    `SDEP_ASSERT_SAME(a_done_count_range, i_clk, i_rst_n, 1'b1,
        r_st.done_count <= DONE_TAG_LEN, "held done-tag count out of range")
    `SDEP_ASSERT_SAME(a_broken_holds_nothing, i_clk, i_rst_n, r_st.done_broken,
        r_st.done_count == 3'd0, "bytes held after the done match broke")

endmodule

`default_nettype wire

[hdl/sdep_queue.sv]
// ----------------------------------------------------------------------------
// sdep_queue
// Small command queue between the classifying front and the output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sse_data_event_parser_macros.svh"

module sdep_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire sdep_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_valid,
    output sdep_pkg::t_cmd     o_cmd
);
    import sdep_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [PW-1:0] LAST_C  = PW'(DEPTH - 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    assign o_full  = (r_count == DEPTH_C);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_C) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_C) ? '0 : r_rd_ptr + PW'(1);
            end
            r_count <= n_count;
        end
    end

    `SDEP_ASSERT_SAME(a_no_overflow, i_clk, i_rst_n, i_push, !o_full,
        "command pushed into a full queue")
    `SDEP_ASSERT_SAME(a_no_underflow, i_clk, i_rst_n, i_pop, o_valid,
        "command popped from an empty queue")

endmodule

`default_nettype wire

[hdl/sdep_back.sv]
// ----------------------------------------------------------------------------
// sdep_back
// Expands queued commands into result transactions, one per cycle while the
// output is not stalled, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sse_data_event_parser_macros.svh"

module sdep_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire sdep_pkg::t_cmd i_q_cmd,
    output logic               o_pop,
    input  wire logic          i_out_stall,
    output logic               o_out_valid,
    output logic [1:0]         o_kind,
    output logic [7:0]         o_data_byte,
    output logic               o_last
);
    import sdep_pkg::*;

    logic [2:0] r_pos;
    logic       r_out_valid;
    logic [1:0] r_kind;
    logic [7:0] r_data_byte;
    logic       r_last;

    logic       load;
    logic [3:0] total;
    logic [3:0] lit_idx;
    logic       is_last;
    t_kind      n_kind;
    logic [7:0] n_byte;

    assign load  = i_q_valid && (!r_out_valid || !i_out_stall);
    assign total = {1'b0, i_q_cmd.flush_n} + {3'b0, i_q_cmd.b0_v}
                   + {3'b0, i_q_cmd.b1_v} + {3'b0, i_q_cmd.mark_v};
    assign is_last = ({1'b0, r_pos} == total - 4'd1);
    assign o_pop   = load && is_last;
    assign lit_idx = {1'b0, r_pos} - {1'b0, i_q_cmd.flush_n};

    // Replayed done-tag bytes first, then literal bytes, then the marker.
    always_comb begin
        n_kind = KIND_DATA;
        n_byte = 8'h00;
        if (r_pos < i_q_cmd.flush_n) begin
            n_byte = done_tag(r_pos);
        end else if (lit_idx == 4'd0 && i_q_cmd.b0_v) begin
            n_byte = i_q_cmd.b0;
        end else if (lit_idx == 4'd1 && i_q_cmd.b1_v) begin
            n_byte = i_q_cmd.b1;
        end else begin
            n_kind = i_q_cmd.mark;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_pos       <= is_last ? 3'd0 : r_pos + 3'd1;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind      <= n_kind;
            r_data_byte <= n_byte;
            r_last      <= is_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_data_byte = r_data_byte;
    assign o_last      = r_last;

    `SDEP_ASSERT_SAME(a_pos_within_cmd, i_clk, i_rst_n, r_pos != 3'd0,
        i_q_valid && {1'b0, r_pos} < total, "result position outside current command")

endmodule

`default_nettype wire

[hdl/sse_data_event_parser.sv]
// ----------------------------------------------------------------------------
// sse_data_event_parser
// Streaming parser that extracts the data of server-sent events from a byte
// stream.
// ----------------------------------------------------------------------------
// The parser takes one raw stream byte per transaction and can accept a byte
// in every cycle. Each byte is classified in the cycle it is accepted: line
// endings (LF, with one preceding CR stripped), the "data:" prefix, comment and
// other lines, and the held-back "[DONE]" match are all resolved there, and the
// byte becomes one command describing its results. Commands wait in a queue of
// DEPTH entries; bytes that cause no result do not enter it. The output side
// turns a command into its results at one result transaction per cycle while
// the output is not stalled, so a byte that releases held "[DONE]" bytes or
// ends an event occupies the output for all of its results (at most eight).
// The input is stalled only while the command queue is full, which happens
// when such bursts or a stalled output outpace the input. Each result
// carries a kind (data byte, end of data event, done event), the data byte
// for data results and zero otherwise, and a last flag that marks the final
// result caused by one input byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sse_data_event_parser #(
    parameter int DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Input byte channel.
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_rx_byte,
    // Result channel.
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_data_byte,
    output logic            o_last
);
    import sdep_pkg::*;

    t_cmd front_cmd;
    t_cmd q_cmd;
    logic front_push;
    logic q_full;
    logic q_valid;
    logic q_pop;

    // Front: line and event tracking, one byte per cycle while the queue has room.
    sdep_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_rx_byte  (i_rx_byte),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (front_push),
        .o_cmd      (front_cmd)
    );

    // Queue: decouples classification from result delivery.
    sdep_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // Back: sequences the results of each command into the output register.
    sdep_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_pop       (q_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_kind      (o_kind),
        .o_data_byte (o_data_byte),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

[tb/sv/tb_sse_data_event_parser.sv]
// ----------------------------------------------------------------------------
// Testbench for the event stream data parser
// Feeds a stream of server-sent event lines (data lines, "[DONE]" markers,
// comments, other fields, CR/LF line endings and random noise) into the
// parser. A scoreboard predicts every result from the bytes accepted and
// checks each result transaction against it, field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sse_data_event_parser;

    import sdep_pkg::*;

    // One predicted result of a stream byte.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_parsed_result;

    // A single byte can release at most this many results.
    localparam int MAX_PER_BYTE = 8;
    localparam logic [7:0] CHR_COLON = 8'h3A;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the parser state, turns every accepted
    // input byte into the results it should cause, and compares the results
    // that come out of the block against them in order.
    // ------------------------------------------------------------------------
    class t_result_board;
        string          data_text = "data:";
        string          done_text = "[DONE]";
        t_phase         phase = PH_START;
        logic [2:0]     tag_pos = '0;
        bit             cr_pending = 1'b0;
        bit             seen_data = 1'b0;
        logic [2:0]     held_cnt = '0;
        bit             done_lost = 1'b0;
        t_parsed_result step_out[$];
        t_parsed_result expected_results[$];
        int             errors = 0;

        function void emit(t_kind k, logic [7:0] d);
            t_parsed_result r;
            if (step_out.size() < MAX_PER_BYTE) begin
                r.kind = k;
                r.data = d;
                r.last = 1'b0;
                step_out.insert(step_out.size(), r);
            end
        endfunction

        // Replays the held-back bytes of a partial "[DONE]" match.
        function void release_held();
            for (int i = 0; i < held_cnt; i++) begin
                emit(KIND_DATA, done_text[i]);
            end
            held_cnt = '0;
        endfunction

        function void feed_value(logic [7:0] b);
            if (done_lost) begin
                emit(KIND_DATA, b);
            end else if (held_cnt < DONE_TAG_LEN && b == done_text[held_cnt]) begin
                held_cnt++;
            end else begin
                done_lost = 1'b1;
                release_held();
                emit(KIND_DATA, b);
            end
        endfunction

        function void feed_line(logic [7:0] b);
            case (phase)
                PH_START: begin
                    if (b == data_text[0]) begin
                        phase   = PH_PREFIX;
                        tag_pos = 3'd1;
                    end else begin
                        phase = PH_SKIP;
                    end
                end
                PH_PREFIX: begin
                    if (tag_pos < DATA_TAG_LEN && b == data_text[tag_pos]) begin
                        tag_pos++;
                        if (tag_pos == DATA_TAG_LEN) begin
                            // A further data line in the same event is joined by LF.
                            if (seen_data) begin
                                feed_value(CHR_LF);
                            end
                            seen_data = 1'b1;
                            phase     = PH_COLON;
                        end
                    end else begin
                        phase = PH_SKIP;
                    end
                end
                PH_COLON: begin
                    phase = PH_VALUE;
                    if (b != CHR_SPACE) begin
                        feed_value(b);
                    end
                end
                PH_VALUE: begin
                    feed_value(b);
                end
                default: begin
                    phase = PH_SKIP;
                end
            endcase
        endfunction

        // A blank line closes the event, but only if data was seen.
        function void close_line();
            if (phase == PH_START && seen_data) begin
                if (!done_lost && held_cnt == DONE_TAG_LEN) begin
                    emit(KIND_DONE, 8'h00);
                end else begin
                    if (!done_lost) begin
                        release_held();
                    end
                    emit(KIND_END, 8'h00);
                end
                seen_data = 1'b0;
                held_cnt  = '0;
                done_lost = 1'b0;
            end
            phase   = PH_START;
            tag_pos = '0;
        endfunction

        // Notes one accepted input transaction and queues its results.
        function void note_byte(logic [7:0] b);
            step_out.delete();
            if (b == CHR_LF) begin
                cr_pending = 1'b0;
                close_line();
            end else if (b == CHR_CR) begin
                // A CR after a held CR releases the first as a line byte.
                if (cr_pending) begin
                    feed_line(CHR_CR);
                end
                cr_pending = 1'b1;
            end else begin
                if (cr_pending) begin
                    cr_pending = 1'b0;
                    feed_line(CHR_CR);
                end
                feed_line(b);
            end
            if (step_out.size() > 0) begin
                step_out[step_out.size() - 1].last = 1'b1;
            end
            foreach (step_out[i]) begin
                expected_results.insert(expected_results.size(), step_out[i]);
            end
        endfunction

        // Checks one accepted result transaction against the oldest prediction.
        function void check_result(logic [1:0] kind, logic [7:0] data, logic last);
            t_parsed_result want;
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing expected: kind %0d data %02h last %0b",
                         $time, kind, data, last);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (kind !== want.kind) begin
                $display("%0t: kind mismatch: expected %0d actual %0d", $time, want.kind, kind);
                errors++;
            end
            if (data !== want.data) begin
                $display("%0t: data_byte mismatch: expected %02h actual %02h",
                         $time, want.data, data);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t: last mismatch: expected %0b actual %0b", $time, want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [1:0] o_kind;
    logic [7:0] o_data_byte;
    logic       o_last;

    t_result_board sb;

    // Idle rates in percent for the sender and the receiver.
    int in_gap_pct = 35;
    int out_stall_pct = 60;
    int bytes_sent = 0;

    sse_data_event_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_rx_byte   (i_rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_kind      (o_kind),
        .o_data_byte (o_data_byte),
        .o_last      (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Result side: a transaction completes at an edge where valid is high and
    // stall is low. Stall is drawn afresh each cycle and never looks at valid.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_kind, o_data_byte, o_last);
        end
        i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    // Presents one byte, with random idle cycles in front, and holds it until
    // the parser accepts it. Valid stays high between back-to-back bytes.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    // A random value byte; LF would end the line, so it is turned into a CR,
    // which also exercises a CR that is not followed by LF.
    function automatic logic [7:0] value_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CHR_LF) begin
            b = CHR_CR;
        end
        return b;
    endfunction

    task automatic send_line_end();
        if ($urandom_range(0, 1) == 1) begin
            send_byte(CHR_CR);
        end
        send_byte(CHR_LF);
    endtask

    // The value of a data line: the full done word, a prefix of it with an
    // optional tail that breaks the match, or plain random bytes.
    task automatic send_data_value();
        string done_word;
        int    n;
        done_word = "[DONE]";
        case ($urandom_range(0, 3))
            0: begin
                send_text(done_word);
            end
            1: begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    send_byte(done_word[i]);
                end
                n = $urandom_range(0, 2);
                for (int i = 0; i < n; i++) begin
                    send_byte(value_byte());
                end
            end
            default: begin
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++) begin
                    send_byte(value_byte());
                end
            end
        endcase
    endtask

    // Lines the parser must skip: comments, other fields, a broken "data:"
    // prefix, and raw noise.
    task automatic send_noise_line();
        string data_word;
        int    n;
        data_word = "data:";
        case ($urandom_range(0, 3))
            0: send_byte(CHR_COLON);
            1: send_text("event:");
            2: begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) begin
                    send_byte(data_word[i]);
                end
            end
            default: ;
        endcase
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) begin
            send_byte(value_byte());
        end
        send_line_end();
    endtask

    // Mostly well-formed events of one to three data lines with random
    // content, sometimes with a skipped line mixed in, and now and then an
    // event made of noise alone. Every event ends with a blank line.
    task automatic send_event();
        int lines;
        if ($urandom_range(0, 4) == 0) begin
            send_noise_line();
        end else begin
            lines = $urandom_range(1, 3);
            for (int i = 0; i < lines; i++) begin
                if ($urandom_range(0, 5) == 0) begin
                    send_noise_line();
                end
                send_text("data:");
                if ($urandom_range(0, 1) == 1) begin
                    send_byte(CHR_SPACE);
                end
                send_data_value();
                send_line_end();
            end
        end
        send_line_end();
    endtask

    task automatic send_random_events(input int target);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < target) begin
            send_event();
        end
    endtask

    // Stops sending and waits until every predicted result has come out, then
    // keeps watching the output so that any stray result shows.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (sb.expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        sb = new;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: a blank line with no data, a comment holding 0xFF,
        // a done event, a dropped space with a done prefix broken by 0x00 and
        // a double CR, an empty data line joined into the event, a partial
        // done prefix at the event end, and a line that is not a data line.
        send_byte(CHR_LF);
        send_byte(CHR_COLON);
        send_byte(8'hFF);
        send_byte(CHR_LF);
        send_text("data:[DONE]\n\n");
        send_text("data: [D");
        send_byte(8'h00);
        send_text("\r\r\n");
        send_text("data:\n\n");
        send_text("data:[DO\r\n\n");
        send_text("dx\n");

        // Receiver stalls more than the sender idles first.
        send_random_events(100);
        wait_for_results();

        // Then the sender idles more than the receiver stalls.
        in_gap_pct    = 60;
        out_stall_pct = 35;
        send_random_events(100);
        wait_for_results();

        // Finally full rate on both sides.
        in_gap_pct    = 0;
        out_stall_pct = 0;
        send_random_events(100);
        wait_for_results();

        if (sb.errors == 0 && sb.expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Safety net against a hung handshake.
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
